### hw/rtl/matrix3_inverse_defines.svh
// Assertion macros used by the matrix inverse top level.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define M3I_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define M3I_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/m3i_pkg.sv
// Shared widths, constants and types of the matrix inverse pipeline.
package m3i_pkg;

   localparam int DATA_W        = 32;
   localparam int LANES         = 9;
   localparam int FRAC_BITS_DEF = 16;

   // Exact internal widths for 32-bit signed entries.
   localparam int PROD_W    = 2 * DATA_W;          // entry times entry
   localparam int ADJ_W     = PROD_W + 1;          // difference of two products
   localparam int ADJ_MAG_W = PROD_W;              // magnitude of a cofactor
   localparam int DPROD_W   = ADJ_W;               // entry times one cofactor half
   localparam int DET_W     = DATA_W + ADJ_W;      // determinant, signed
   localparam int DET_MAG_W = DET_W - 1;           // determinant magnitude
   localparam int Q_W       = DATA_W;              // quotient bits kept

   localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef logic signed [DATA_W-1:0] word_type;

   // Per-item control that rides along the divider stages.
   typedef struct packed {
      logic             singular;
      logic [LANES-1:0] neg;
   } ctl_type;

endpackage

### hw/rtl/m3i_channels.sv
// Request and response channel interfaces of the matrix inverse.
interface m3i_req_if
   import m3i_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type m00, m01, m02;
   word_type m10, m11, m12;
   word_type m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface m3i_rsp_if
   import m3i_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type r00, r01, r02;
   word_type r10, r11, r12;
   word_type r20, r21, r22;
   logic     singular;
   logic     saturated;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, saturated, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, saturated, output ready);
endinterface

### hw/rtl/m3i_cofactor.sv
// Front pipeline: cofactors, determinant and divider operands.
module m3i_cofactor
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int NUM_W = ADJ_MAG_W + 2 * FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  word_type             in_m [LANES],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [NUM_W-1:0]     out_num [LANES],
   output logic [DET_MAG_W-1:0] out_dmag,
   output ctl_type              out_ctl
);

   localparam int NS = 6;

   logic [NS:1] v_ff;
   logic [NS:1] v_in;
   logic [NS:1] en;

   logic signed [PROD_W-1:0]  pa_in [LANES];
   logic signed [PROD_W-1:0]  pb_in [LANES];
   logic signed [PROD_W-1:0]  pa_ff [LANES];
   logic signed [PROD_W-1:0]  pb_ff [LANES];
   word_type                  row0_1_ff [3];
   word_type                  row0_2_ff [3];
   logic signed [ADJ_W-1:0]   adj_in [LANES];
   logic signed [ADJ_W-1:0]   adj_ff [LANES];
   logic signed [DPROD_W-1:0] dlo_in [3];
   logic signed [DPROD_W-1:0] dhi_in [3];
   logic signed [DPROD_W-1:0] dlo_ff [3];
   logic signed [DPROD_W-1:0] dhi_ff [3];
   logic [ADJ_MAG_W-1:0]      amag_in [LANES];
   logic [ADJ_MAG_W-1:0]      amag3_ff [LANES];
   logic [ADJ_MAG_W-1:0]      amag4_ff [LANES];
   logic [ADJ_MAG_W-1:0]      amag5_ff [LANES];
   logic [LANES-1:0]          asgn_in;
   logic [LANES-1:0]          asgn3_ff;
   logic [LANES-1:0]          asgn4_ff;
   logic [LANES-1:0]          asgn5_ff;
   logic signed [DET_W-1:0]   dp_in [3];
   logic signed [DET_W-1:0]   dp_ff [3];
   logic signed [DET_W-1:0]   det_in;
   logic signed [DET_W-1:0]   det_ff;
   logic [NUM_W-1:0]          num_in [LANES];
   logic [NUM_W-1:0]          num_ff [LANES];
   logic [DET_MAG_W-1:0]      dmag_in;
   logic [DET_MAG_W-1:0]      dmag_ff;
   ctl_type                   ctl_in;
   ctl_type                   ctl_ff;

   // A stage moves when some stage at or after it is empty, or the output drains.
   assign v_in = {v_ff[NS-1:1], in_valid};
   for (genvar k = 1; k <= NS; k++) begin : g_en
      assign en[k] = out_ready || !(&v_ff[NS:k]);
   end
   assign in_ready = en[1];

   // Stage 1: the two products of every cofactor (adjugate is the cofactor transpose).
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int I1 = (i + 1) % 3;
         localparam int I2 = (i + 2) % 3;
         localparam int J1 = (j + 1) % 3;
         localparam int J2 = (j + 2) % 3;
         assign pa_in[i*3+j] = PROD_W'(in_m[J1*3+I1]) * PROD_W'(in_m[J2*3+I2]);
         assign pb_in[i*3+j] = PROD_W'(in_m[J1*3+I2]) * PROD_W'(in_m[J2*3+I1]);
      end
   end

   // Stage 2: adjugate entries.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         adj_in[l] = ADJ_W'(pa_ff[l]) - ADJ_W'(pb_ff[l]);
      end
   end

   // Stage 3: row 0 times column 0 of the adjugate, each cofactor split in halves.
   for (genvar j = 0; j < 3; j++) begin : g_dprod
      assign dlo_in[j] = DPROD_W'(row0_2_ff[j])
                       * DPROD_W'($signed({1'b0, adj_ff[3*j][DATA_W-1:0]}));
      assign dhi_in[j] = DPROD_W'(row0_2_ff[j])
                       * DPROD_W'($signed(adj_ff[3*j][ADJ_W-1:DATA_W]));
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         asgn_in[l] = adj_ff[l][ADJ_W-1];
         amag_in[l] = adj_ff[l][ADJ_W-1] ? ADJ_MAG_W'(-adj_ff[l]) : ADJ_MAG_W'(adj_ff[l]);
      end
   end

   // Stage 4: recombine the halves. Stage 5: sum the three terms.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dp_in[j] = (DET_W'(dhi_ff[j]) <<< DATA_W) + DET_W'(dlo_ff[j]);
      end
      det_in = dp_ff[0] + dp_ff[1] + dp_ff[2];
   end

   // Stage 6: magnitudes and signs for the unsigned divider.
   always_comb begin
      dmag_in         = det_ff[DET_W-1] ? DET_MAG_W'(-det_ff) : DET_MAG_W'(det_ff);
      ctl_in.singular = (det_ff == '0);
      ctl_in.neg      = asgn5_ff ^ {LANES{det_ff[DET_W-1]}};
      for (int l = 0; l < LANES; l++) begin
         num_in[l] = {amag5_ff[l], {(2 * FRAC_BITS){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         for (int j = 0; j < 3; j++) begin
            row0_1_ff[j] <= in_m[j];
         end
      end
      if (en[2]) begin
         adj_ff    <= adj_in;
         row0_2_ff <= row0_1_ff;
      end
      if (en[3]) begin
         dlo_ff   <= dlo_in;
         dhi_ff   <= dhi_in;
         amag3_ff <= amag_in;
         asgn3_ff <= asgn_in;
      end
      if (en[4]) begin
         dp_ff    <= dp_in;
         amag4_ff <= amag3_ff;
         asgn4_ff <= asgn3_ff;
      end
      if (en[5]) begin
         det_ff   <= det_in;
         amag5_ff <= amag4_ff;
         asgn5_ff <= asgn4_ff;
      end
      if (en[6]) begin
         num_ff  <= num_in;
         dmag_ff <= dmag_in;
         ctl_ff  <= ctl_in;
      end
   end

   assign out_valid = v_ff[NS];
   assign out_num   = num_ff;
   assign out_dmag  = dmag_ff;
   assign out_ctl   = ctl_ff;

endmodule

### hw/rtl/m3i_divider.sv
// Nine-lane restoring divider: an overflow check stage, then one quotient bit per pipeline stage.
module m3i_divider
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int NUM_W = ADJ_MAG_W + 2 * FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [NUM_W-1:0]     in_num [LANES],
   input  logic [DET_MAG_W-1:0] in_dmag,
   input  ctl_type              in_ctl,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [Q_W-1:0]       out_q [LANES],
   output logic [LANES-1:0]     out_big,
   output ctl_type              out_ctl
);

   localparam int CW = ((NUM_W > DET_MAG_W + Q_W) ? NUM_W : DET_MAG_W + Q_W) + 1;

   logic [Q_W:0] v_ff;
   logic [Q_W:0] v_in;
   logic [Q_W:0] en;

   logic [NUM_W-1:0]     rem_ff [Q_W][LANES];
   logic [NUM_W-1:0]     rem_in [Q_W][LANES];
   logic [DET_MAG_W-1:0] d_ff [Q_W];
   logic [DET_MAG_W-1:0] d_in [Q_W];
   logic [CW-1:0]        diff [Q_W][LANES];
   logic [Q_W-1:0]       q_ff [Q_W+1][LANES];
   logic [Q_W-1:0]       q_in [Q_W+1][LANES];
   logic [LANES-1:0]     big_ff [Q_W+1];
   logic [LANES-1:0]     big_in [Q_W+1];
   ctl_type              ctl_ff [Q_W+1];
   ctl_type              ctl_in [Q_W+1];

   assign v_in = {v_ff[Q_W-1:0], in_valid};
   for (genvar t = 0; t <= Q_W; t++) begin : g_en
      assign en[t] = out_ready || !(&v_ff[Q_W:t]);
   end
   assign in_ready = en[0];

   // Trial subtraction of each stage against the divisor shifted to its bit.
   always_comb begin
      for (int t = 0; t < Q_W; t++) begin
         for (int l = 0; l < LANES; l++) begin
            diff[t][l] = CW'(rem_ff[t][l]) - (CW'(d_ff[t]) << (Q_W - 1 - t));
         end
      end
   end

   always_comb begin
      // Entry stage: flag quotients that do not fit in Q_W bits.
      rem_in[0] = in_num;
      d_in[0]   = in_dmag;
      ctl_in[0] = in_ctl;
      for (int l = 0; l < LANES; l++) begin
         q_in[0][l]   = '0;
         big_in[0][l] = CW'(in_num[l]) >= (CW'(in_dmag) << Q_W);
      end
      for (int t = 1; t <= Q_W; t++) begin
         ctl_in[t] = ctl_ff[t-1];
         big_in[t] = big_ff[t-1];
         for (int l = 0; l < LANES; l++) begin
            q_in[t][l] = {q_ff[t-1][l][Q_W-2:0], ~diff[t-1][l][CW-1]};
         end
      end
      for (int t = 1; t < Q_W; t++) begin
         d_in[t] = d_ff[t-1];
         for (int l = 0; l < LANES; l++) begin
            rem_in[t][l] = diff[t-1][l][CW-1] ? rem_ff[t-1][l] : diff[t-1][l][NUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int t = 0; t <= Q_W; t++) begin
            if (en[t]) begin
               v_ff[t] <= v_in[t];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t <= Q_W; t++) begin
         if (en[t]) begin
            q_ff[t]   <= q_in[t];
            big_ff[t] <= big_in[t];
            ctl_ff[t] <= ctl_in[t];
         end
      end
      for (int t = 0; t < Q_W; t++) begin
         if (en[t]) begin
            rem_ff[t] <= rem_in[t];
            d_ff[t]   <= d_in[t];
         end
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_q     = q_ff[Q_W];
   assign out_big   = big_ff[Q_W];
   assign out_ctl   = ctl_ff[Q_W];

endmodule

### hw/rtl/matrix3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
// Each item on req_ch is one 3x3 matrix of signed fixed-point entries with
// FRAC_BITS fraction bits (8 to 30, default 16); each item on rsp_ch is its
// inverse in the same format, formed as the adjugate divided by the exact
// determinant, truncated toward zero and clamped to the 32-bit range. The
// saturated flag is set when any entry was clamped. A matrix whose
// determinant is exactly zero returns nine zeros with singular set and
// saturated clear. The block takes one item every cycle until a result held
// on rsp_ch backs the pipeline up to the input. An accepted item passes 40
// register stages: six front stages build the cofactors and the determinant
// with multipliers no wider than 32 by 33 bits, then 33 divider stages (one
// overflow check plus one restoring step per quotient bit, for 32 quotient
// bits) and one output register. Every stage keeps its own valid bit, so
// items keep entering while a finished result waits on rsp_ch, until the
// pipeline is full.
`include "matrix3_inverse_defines.svh"
module matrix3_inverse
   import m3i_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   m3i_req_if.sink   req_ch,
   m3i_rsp_if.source rsp_ch
);

   localparam int NUM_W = ADJ_MAG_W + 2 * FRAC_BITS;

   word_type             in_m [LANES];
   logic                 cof_valid;
   logic                 cof_ready;
   logic [NUM_W-1:0]     cof_num [LANES];
   logic [DET_MAG_W-1:0] cof_dmag;
   ctl_type              cof_ctl;
   logic                 div_valid;
   logic [Q_W-1:0]       div_q [LANES];
   logic [LANES-1:0]     div_big;
   ctl_type              div_ctl;

   logic                 en_out;
   logic                 rsp_v_ff;
   logic [DATA_W-1:0]    r_ff [LANES];
   logic [DATA_W-1:0]    r_in [LANES];
   logic                 singular_ff;
   logic                 saturated_ff;
   logic [LANES-1:0]     sat_lane;
   logic                 clamp_seen;
   logic                 zero_seen;

   // Row-major matrix entries, lane index is row * 3 + column.
   assign in_m[0] = req_ch.m00;
   assign in_m[1] = req_ch.m01;
   assign in_m[2] = req_ch.m02;
   assign in_m[3] = req_ch.m10;
   assign in_m[4] = req_ch.m11;
   assign in_m[5] = req_ch.m12;
   assign in_m[6] = req_ch.m20;
   assign in_m[7] = req_ch.m21;
   assign in_m[8] = req_ch.m22;

   m3i_cofactor #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_m      (in_m),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_num   (cof_num),
      .out_dmag  (cof_dmag),
      .out_ctl   (cof_ctl)
   );

   m3i_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_num    (cof_num),
      .in_dmag   (cof_dmag),
      .in_ctl    (cof_ctl),
      .out_valid (div_valid),
      .out_ready (en_out),
      .out_q     (div_q),
      .out_big   (div_big),
      .out_ctl   (div_ctl)
   );

   // The output register loads whenever it is empty or its item is being taken.
   assign en_out = !rsp_v_ff || rsp_ch.ready;

   // Apply the sign and clamp each quotient. A negative result may reach
   // exactly the most negative code; a positive one stops one below.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         r_in[l]     = '0;
         sat_lane[l] = 1'b0;
         if (div_ctl.singular) begin
            r_in[l] = '0;
         end else if (div_ctl.neg[l]) begin
            if (div_big[l] || (div_q[l][Q_W-1] && |div_q[l][Q_W-2:0])) begin
               r_in[l]     = NEG_MIN;
               sat_lane[l] = 1'b1;
            end else begin
               r_in[l] = DATA_W'(-div_q[l]);
            end
         end else if (div_big[l] || div_q[l][Q_W-1]) begin
            r_in[l]     = POS_MAX;
            sat_lane[l] = 1'b1;
         end else begin
            r_in[l] = DATA_W'(div_q[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         r_ff         <= r_in;
         singular_ff  <= div_ctl.singular;
         saturated_ff <= !div_ctl.singular && (|sat_lane);
      end
   end

   assign rsp_ch.valid     = rsp_v_ff;
   assign rsp_ch.r00       = r_ff[0];
   assign rsp_ch.r01       = r_ff[1];
   assign rsp_ch.r02       = r_ff[2];
   assign rsp_ch.r10       = r_ff[3];
   assign rsp_ch.r11       = r_ff[4];
   assign rsp_ch.r12       = r_ff[5];
   assign rsp_ch.r20       = r_ff[6];
   assign rsp_ch.r21       = r_ff[7];
   assign rsp_ch.r22       = r_ff[8];
   assign rsp_ch.singular  = singular_ff;
   assign rsp_ch.saturated = saturated_ff;

   // Summaries of the held result, used by the checks below.
   always_comb begin
      clamp_seen = 1'b0;
      zero_seen  = 1'b1;
      for (int l = 0; l < LANES; l++) begin
         if (r_ff[l] == POS_MAX || r_ff[l] == NEG_MIN) begin
            clamp_seen = 1'b1;
         end
         if (r_ff[l] != '0) begin
            zero_seen = 1'b0;
         end
      end
   end

   // A singular result is all zeros and never marked as clamped.
   `M3I_ASSERT_SAME(a_singular_clean, clock, reset,
      rsp_ch.valid && rsp_ch.singular, zero_seen && !rsp_ch.saturated,
      "singular result is not clean")
   // The saturated flag always comes with at least one entry at a clamp value.
   `M3I_ASSERT_SAME(a_sat_has_clamp, clock, reset,
      rsp_ch.valid && rsp_ch.saturated, clamp_seen,
      "saturated flag without a clamped entry")
   // Input back-pressure can only start from a held result at the output.
   `M3I_ASSERT_SAME(a_stall_source, clock, reset,
      !req_ch.ready, rsp_ch.valid && !rsp_ch.ready,
      "input stalled while the output drains")
   // Reset empties the pipeline, so no result is offered right after it.
   `M3I_ASSERT_NEXT(a_reset_empty, clock, 1'b0,
      reset, !rsp_ch.valid,
      "result offered after reset")

endmodule
